/* rtl/ilwh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ilwh_pkg;

  // configuration register indexes
  localparam logic [1:0] CfgEntries = 2'd0;
  localparam logic [1:0] CfgSafety  = 2'd1;
  localparam logic [1:0] CfgHold    = 2'd2;

  // item kinds
  localparam logic KindLoad = 1'b0;
  localparam logic KindEval = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [3:0]         entry_index;
    logic signed [31:0] calib_temp;
    logic signed [31:0] margin_up;
    logic signed [31:0] margin_down;
    logic signed [31:0] base_temp;
    logic signed [31:0] set_point;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] upper_limit;
    logic signed [31:0] lower_limit;
    logic               enable_out;
    logic [14:0]        hold_count;
  } out_item_t;

  // one calibration table row
  typedef struct packed {
    logic signed [31:0] calib;
    logic signed [31:0] up;
    logic signed [31:0] down;
  } entry_t;

  // operands of one interpolation step: num * dy / dx
  typedef struct packed {
    logic signed [32:0] num;
    logic signed [32:0] dy;
    logic signed [32:0] dx;
  } md_req_t;

  // saturate a 35-bit signed sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -35'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/interp_limit_window_holdoff_core.sv */
// evaluate: busy_o stays high through the serial table scan over the memory's
// one read port, the multiply states MD_MUL0 and MD_MUL1 and the 33-step
// restoring divider (scan and divider skipped when the base clamps to an end
// entry); its result beat follows in the next cycle
// throughput: one item at a time, the next accepted once busy_o drops; a load
// completes in the cycle it is accepted
// reset: asynchronous active low; config returns to 2 entries, unity safety
// factor, zero hold delay; hold-off counter cleared, table contents undefined
`timescale 1ns / 1ps
`default_nettype none

module interp_limit_window_holdoff_core
  import ilwh_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire in_item_t   in_item_i,
  output logic            result_valid_o,
  output out_item_t       result_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = (NW > 5) ? NW : 5;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LAST  = 7'b0000010,
    S_FIRST = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_WMUL  = 7'b0100000,
    S_WCMP  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [4:0]  ent_q;
  logic [15:0] sf_q;
  logic [14:0] hd_q, hold_q;

  logic signed [31:0] base_q, sp_q;
  entry_t             last_q, prev_q;
  logic [IW-1:0]      k_q, lastidx_q;
  logic signed [33:0] upm_q, dnm_q;
  logic signed [31:0] m0u_q, m0d_q;
  logic signed [50:0] upsf_q, dnsf_q;
  logic               done_q;
  out_item_t          res_q;

  // memory ports
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;

  // divider ports
  logic        md_start, md_up_done, md_dn_done, md_up_neg, md_dn_neg;
  logic [32:0] md_up_quot, md_dn_quot;
  md_req_t     md_up_req, md_dn_req;

  logic          accept;
  logic [EW-1:0] ent_ext, ld_ext, n_ext;
  logic [IW-1:0] n_last;
  logic          ld_ok;
  entry_t        cur;
  logic          hit, seg_take, dx_zero;

  assign accept  = start_i && !busy_o;
  assign busy_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // clamp of the entry count
  assign ent_ext = EW'(ent_q);
  always_comb begin
    if (ent_ext < EW'(2)) begin
      n_ext = EW'(2);
    end else if (ent_ext > EW'(TABLE_DEPTH)) begin
      n_ext = EW'(TABLE_DEPTH);
    end else begin
      n_ext = ent_ext;
    end
  end
  assign n_last = IW'(n_ext - EW'(1));

  // load beats write the table directly
  assign ld_ext    = EW'(in_item_i.entry_index);
  assign ld_ok     = ld_ext < EW'(TABLE_DEPTH);
  assign ram_we    = accept && (in_item_i.kind == KindLoad) && ld_ok;
  assign ram_waddr = IW'(in_item_i.entry_index);
  assign ram_wdata = '{calib: in_item_i.calib_temp, up: in_item_i.margin_up,
                       down: in_item_i.margin_down};

  ilwh_ram #(
    .Width($bits(entry_t)),
    .Depth(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // segment test on the previous and current rows
  assign cur = ram_rdata;
  assign hit = ((base_q >= prev_q.calib) && (base_q <= cur.calib)) ||
               ((base_q >= cur.calib) && (base_q <= prev_q.calib));
  assign seg_take = hit || (k_q == lastidx_q);
  assign dx_zero  = (cur.calib == prev_q.calib);

  assign md_up_req = '{num: 33'(base_q) - 33'(prev_q.calib),
                       dy: 33'(cur.up) - 33'(prev_q.up),
                       dx: 33'(cur.calib) - 33'(prev_q.calib)};
  assign md_dn_req = '{num: 33'(base_q) - 33'(prev_q.calib),
                       dy: 33'(cur.down) - 33'(prev_q.down),
                       dx: 33'(cur.calib) - 33'(prev_q.calib)};

  ilwh_muldiv u_md_up (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(md_start),
    .req_i  (md_up_req),
    .done_o (md_up_done),
    .quot_o (md_up_quot),
    .neg_o  (md_up_neg)
  );

  ilwh_muldiv u_md_dn (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(md_start),
    .req_i  (md_dn_req),
    .done_o (md_dn_done),
    .quot_o (md_dn_quot),
    .neg_o  (md_dn_neg)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    ram_re    = 1'b0;
    ram_raddr = '0;
    md_start  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        ram_raddr = n_last;
        if (accept && (in_item_i.kind == KindEval)) begin
          ram_re  = 1'b1;
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_d   = S_FIRST;
      end
      S_FIRST: begin
        if ((base_q > cur.calib) || (base_q < last_q.calib)) begin
          state_d = S_WMUL;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = IW'(1);
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (seg_take) begin
          if (dx_zero) begin
            state_d = S_WMUL;
          end else begin
            md_start = 1'b1;
            state_d  = S_DIV;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = k_q + IW'(1);
        end
      end
      S_DIV:  if (md_up_done && md_dn_done) state_d = S_WMUL;
      S_WMUL: state_d = S_WCMP;
      S_WCMP: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // window compare and limits
  logic signed [51:0] sp256, base256, win_lo, win_hi;
  logic               in_win;
  logic signed [34:0] up_sum, dn_sum;
  logic [14:0]        hold_d;
  logic               en_d;

  assign sp256   = {{12{sp_q[31]}}, sp_q, 8'd0};
  assign base256 = {{12{base_q[31]}}, base_q, 8'd0};
  assign win_lo  = base256 - 52'(dnsf_q);
  assign win_hi  = base256 + 52'(upsf_q);
  assign in_win  = (sp256 > win_lo) && (sp256 < win_hi);
  assign up_sum  = 35'(base_q) + 35'(upm_q);
  assign dn_sum  = 35'(base_q) - 35'(dnm_q);

  always_comb begin
    priority if (in_win) begin
      hold_d = hd_q;
      en_d   = 1'b1;
    end else if (hold_q != '0) begin
      hold_d = hold_q - 15'd1;
      en_d   = 1'b1;
    end else begin
      hold_d = '0;
      en_d   = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ent_q   <= 5'd2;
      sf_q    <= 16'd256;
      hd_q    <= '0;
      hold_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_WCMP);
      if (state_q == S_WCMP) begin
        hold_q <= hold_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgEntries: ent_q <= cfg_data_i[4:0];
          CfgSafety:  sf_q  <= cfg_data_i;
          CfgHold:    hd_q  <= cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        base_q    <= in_item_i.base_temp;
        sp_q      <= in_item_i.set_point;
        lastidx_q <= n_last;
        k_q       <= IW'(1);
      end
      S_LAST: last_q <= cur;
      S_FIRST: begin
        prev_q <= cur;
        if (base_q > cur.calib) begin
          upm_q <= 34'(cur.up);
          dnm_q <= 34'(cur.down);
        end else begin
          upm_q <= 34'(last_q.up);
          dnm_q <= 34'(last_q.down);
        end
      end
      S_SCAN: begin
        upm_q <= 34'(prev_q.up);
        dnm_q <= 34'(prev_q.down);
        m0u_q <= prev_q.up;
        m0d_q <= prev_q.down;
        if (!seg_take) begin
          prev_q <= cur;
          k_q    <= k_q + IW'(1);
        end
      end
      S_DIV: begin
        upm_q <= md_up_neg ? 34'(m0u_q) - 34'(md_up_quot) : 34'(m0u_q) + 34'(md_up_quot);
        dnm_q <= md_dn_neg ? 34'(m0d_q) - 34'(md_dn_quot) : 34'(m0d_q) + 34'(md_dn_quot);
      end
      S_WMUL: begin
        upsf_q <= 51'(upm_q * $signed({1'b0, sf_q}));
        dnsf_q <= 51'(dnm_q * $signed({1'b0, sf_q}));
      end
      S_WCMP: begin
        res_q.upper_limit <= sat32(up_sum);
        res_q.lower_limit <= sat32(dn_sum);
        res_q.enable_out  <= en_d;
        res_q.hold_count  <= hold_d;
      end
      default: ;
    endcase
  end

  assign result_valid_o = done_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

/* rtl/ilwh_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module ilwh_ram #(
  parameter int Width = 96,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/ilwh_muldiv.sv */
`timescale 1ns / 1ps
`default_nettype none

module ilwh_muldiv
  import ilwh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire md_req_t     req_i,
  output logic             done_o,
  output logic [32:0]      quot_o,
  output logic             neg_o
);

  typedef enum logic [3:0] {
    MD_IDLE = 4'b0001,
    MD_MUL0 = 4'b0010,
    MD_MUL1 = 4'b0100,
    MD_DIV  = 4'b1000
  } md_state_e;

  md_state_e   state_q, state_d;
  logic [32:0] a_q, b_q, d_q;
  logic        neg_q;
  logic [65:0] prod_q;
  logic [32:0] rem_q, quo_q;
  logic [5:0]  cnt_q;
  logic        done_q;

  logic [49:0] pp_lo;
  logic [48:0] pp_hi;
  logic [65:0] prod_sum;
  logic [33:0] trial;
  logic        fits;

  // partial products of the two multiplier halves
  assign pp_lo = a_q * b_q[16:0];
  assign pp_hi = a_q * b_q[32:17];

  // upper partial product joins the lower one
  assign prod_sum = prod_q + {pp_hi, 17'd0};

  // one restoring divide step
  assign trial = {rem_q, quo_q[32]};
  assign fits  = (trial >= {1'b0, d_q});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MD_IDLE: if (start_i) state_d = MD_MUL0;
      MD_MUL0: state_d = MD_MUL1;
      MD_MUL1: state_d = MD_DIV;
      MD_DIV:  if (cnt_q == 6'd32) state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == MD_DIV) && (cnt_q == 6'd32);
      if (state_q == MD_MUL1) begin
        cnt_q <= '0;
      end else if (state_q == MD_DIV) begin
        cnt_q <= cnt_q + 6'd1;
      end
    end
  end

  // operand magnitudes, product and quotient
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      MD_IDLE: begin
        a_q   <= req_i.num[32] ? 33'(-req_i.num) : req_i.num;
        b_q   <= req_i.dy[32]  ? 33'(-req_i.dy)  : req_i.dy;
        d_q   <= req_i.dx[32]  ? 33'(-req_i.dx)  : req_i.dx;
        neg_q <= req_i.num[32] ^ req_i.dy[32] ^ req_i.dx[32];
      end
      MD_MUL0: prod_q <= {16'd0, pp_lo};
      MD_MUL1: begin
        rem_q <= prod_sum[65:33];
        quo_q <= prod_sum[32:0];
      end
      MD_DIV: begin
        rem_q <= fits ? 33'(trial - {1'b0, d_q}) : trial[32:0];
        quo_q <= {quo_q[31:0], fits};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign neg_o  = neg_q;

endmodule

`default_nettype wire

/* rtl/ilwh_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module ilwh_checker
  import ilwh_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start_i,
  input wire logic      busy_o,
  input wire in_item_t  in_item_i,
  input wire logic      result_valid_o,
  input wire out_item_t result_o
);

  // a result beat never repeats in the next cycle
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result beat repeated");

  // a result follows a busy cycle
  a_busy_before: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result without work");

  // an accepted evaluate makes the block busy
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && in_item_i.kind == KindEval) |=> busy_o)
    else $error("evaluate not taken");

  // a load gives no result beat
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && in_item_i.kind == KindLoad) |=> !result_valid_o)
    else $error("load produced a result");

  // switch-off only with an exhausted counter
  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.enable_out) |-> (result_o.hold_count == '0))
    else $error("disabled with hold count left");

endmodule

bind interp_limit_window_holdoff_core ilwh_checker u_ilwh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .in_item_i     (in_item_i),
  .result_valid_o(result_valid_o),
  .result_o      (result_o)
);

`default_nettype wire
